### hw/rtl/scaled_varint_stream_decoder_unit_macros.svh
// Assertion macros shared by the scaled varint stream decoder RTL.
`ifndef SCALED_VARINT_STREAM_DECODER_UNIT_MACROS_SVH
`define SCALED_VARINT_STREAM_DECODER_UNIT_MACROS_SVH

// Plain property check, sampled on clk and quiet while arst_n is low.
`define SVDEC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication check.
`define SVDEC_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hw/rtl/svdec_pkg.sv
// Types and constants shared by the scaled varint stream decoder modules.
package svdec_pkg;

	localparam int BYTE_W  = 8;
	localparam int MAG_W   = 56;
	localparam int VALUE_W = 64;
	localparam int LEN_W   = 4;
	localparam int LANES   = MAG_W / BYTE_W;

	// Header byte layout.
	localparam logic [BYTE_W-1:0] SCALE_MASK = 8'h03;
	localparam logic [BYTE_W-1:0] SMALL_MASK = 8'h0c;
	localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h70;
	localparam logic [BYTE_W-1:0] SIGN_MASK  = 8'h80;

	typedef enum logic [1:0] {
		SCALE_1    = 2'd0,
		SCALE_10   = 2'd1,
		SCALE_100  = 2'd2,
		SCALE_1000 = 2'd3
	} scale_t;

	// One finished record on its way from the assembler to the scaler.
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		scale_t           scale;
		logic             neg;
		logic [LEN_W-1:0] len;
	} rec_t;

endpackage

### hw/rtl/scaled_varint_stream_decoder_unit.sv
// Top level of the scaled varint stream decoder.
//
//   channel   signals                           direction   carries
//   byte      byte_valid byte_stall in_byte     into block  one stream byte per item
//   result    result_valid result_stall         out of block one decoded record per item
//             value record_length
//
// One byte is taken every cycle while the result side keeps up; records of one
// byte and records with payload alike cost one cycle per byte.
// The byte that ends a record passes the assembler register, the scaled product
// register, then the signed result register before its result appears.
// Reset clears the parser state and all stage valid flags; a partial record is lost.
// A stalled result holds its stage; byte_stall rises only once every stage is full.
`include "scaled_varint_stream_decoder_unit_macros.svh"

module scaled_varint_stream_decoder_unit import svdec_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	output logic                      byte_stall,
	input  logic [BYTE_W-1:0]         in_byte,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic [LEN_W-1:0]          record_length
);

	logic rec_valid;
	logic rec_stall;
	rec_t rec;

	svdec_assembler u_assembler (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec        (rec)
	);

	svdec_scaler u_scaler (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (rec_valid),
		.rec_stall     (rec_stall),
		.rec           (rec),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.value         (value),
		.record_length (record_length)
	);

	// A record of one byte never carries more than the two-bit small value.
	`SVDEC_IMPLY(a_short_rec_small, rec_valid && (rec.len == 4'd1), rec.mag[MAG_W-1:2] == '0, "one-byte record with wide magnitude")
	// Record lengths run from one to eight bytes.
	`SVDEC_IMPLY(a_len_range, result_valid, (record_length != 4'd0) && (record_length <= 4'd8), "record length out of range")
	// Input is held back only when the assembler output is still occupied.
	`SVDEC_IMPLY(a_stall_cause, byte_stall, rec_valid && rec_stall, "byte stall without a full pipeline")

endmodule

### hw/rtl/svdec_assembler.sv
// Byte assembler: parses headers and gathers little-endian payload into records.
module svdec_assembler import svdec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              rec_valid,
	input  logic              rec_stall,
	output rec_t              rec
);

	logic [BYTE_W-1:0] hdr_q;
	logic [2:0]        remaining_q;
	logic [2:0]        index_q;
	logic [MAG_W-1:0]  acc_q;
	rec_t              rec_s1;
	logic              rec_valid_s1;

	logic              take;
	logic              is_hdr;
	logic [1:0]        small_val;
	logic [2:0]        count_val;
	logic [MAG_W-1:0]  acc_new;
	logic              hdr_done;
	logic              pay_done;
	rec_t              rec_next;

	assign byte_stall = rec_valid_s1 && rec_stall;
	assign take       = byte_valid && !byte_stall;
	assign is_hdr     = (remaining_q == 3'd0);
	assign small_val  = 2'((in_byte & SMALL_MASK) >> 2);
	assign count_val  = 3'((in_byte & COUNT_MASK) >> 4);
	assign hdr_done   = is_hdr && ((small_val != 2'd0) || (count_val == 3'd0));
	assign pay_done   = !is_hdr && (remaining_q == 3'd1);

	// The incoming payload byte lands in the lane picked by the byte index.
	always_comb begin
		acc_new = acc_q;
		for (int i = 0; i < LANES; i++) begin
			if (index_q == 3'(i)) begin
				acc_new[i*BYTE_W +: BYTE_W] = acc_q[i*BYTE_W +: BYTE_W] | in_byte;
			end
		end
	end

	always_comb begin
		if (is_hdr) begin
			rec_next.mag   = MAG_W'(small_val);
			rec_next.scale = scale_t'(in_byte[1:0]);
			rec_next.neg   = |(in_byte & SIGN_MASK);
			rec_next.len   = LEN_W'(1);
		end else begin
			rec_next.mag   = acc_new;
			rec_next.scale = scale_t'(hdr_q[1:0]);
			rec_next.neg   = |(hdr_q & SIGN_MASK);
			rec_next.len   = LEN_W'((hdr_q & COUNT_MASK) >> 4) + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q        <= '0;
			remaining_q  <= '0;
			index_q      <= '0;
			acc_q        <= '0;
			rec_valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				if (is_hdr) begin
					if (!hdr_done) begin
						hdr_q       <= in_byte;
						remaining_q <= count_val;
						acc_q       <= '0;
						index_q     <= '0;
					end
				end else if (pay_done) begin
					remaining_q <= '0;
					acc_q       <= '0;
					index_q     <= '0;
				end else begin
					remaining_q <= remaining_q - 3'd1;
					acc_q       <= acc_new;
					index_q     <= index_q + 3'd1;
				end
			end
			if (take && (hdr_done || pay_done)) begin
				rec_valid_s1 <= 1'b1;
			end else if (!rec_stall) begin
				rec_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (hdr_done || pay_done)) begin
			rec_s1 <= rec_next;
		end
	end

	assign rec_valid = rec_valid_s1;
	assign rec       = rec_s1;

endmodule

### hw/rtl/svdec_scaler.sv
// Scaler: multiplies the magnitude by 1, 10, 100 or 1000 and applies the sign.
module svdec_scaler import svdec_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rec_valid,
	output logic                      rec_stall,
	input  rec_t                      rec,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic [LEN_W-1:0]          record_length
);

	logic [VALUE_W-1:0] prod_s2;
	logic               neg_s2;
	logic [LEN_W-1:0]   len_s2;
	logic               valid_s2;

	logic [VALUE_W-1:0] value_q;
	logic [LEN_W-1:0]   len_q;
	logic               valid_q;

	logic [VALUE_W-1:0] m;
	logic [VALUE_W-1:0] prod;
	logic               out_ready;
	logic               s2_ready;

	assign out_ready = !valid_q || !result_stall;
	assign s2_ready  = !valid_s2 || out_ready;
	assign rec_stall = !s2_ready;

	// Constant multiply as at most three shifted terms, wrapping at 64 bits.
	assign m = VALUE_W'(rec.mag);
	always_comb begin
		case (rec.scale)
			SCALE_1:    prod = m;
			SCALE_10:   prod = (m << 3) + (m << 1);
			SCALE_100:  prod = (m << 6) + (m << 5) + (m << 2);
			SCALE_1000: prod = (m << 10) - (m << 4) - (m << 3);
			default:    prod = m;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= rec_valid;
			end
			if (out_ready) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && rec_valid) begin
			prod_s2 <= prod;
			neg_s2  <= rec.neg;
			len_s2  <= rec.len;
		end
		if (out_ready && valid_s2) begin
			value_q <= neg_s2 ? (VALUE_W'(0) - prod_s2) : prod_s2;
			len_q   <= len_s2;
		end
	end

	assign result_valid  = valid_q;
	assign value         = value_q;
	assign record_length = len_q;

endmodule

### test/scaled_varint_stream_decoder_unit_checker.sv
// Checker that decodes the observed byte stream and compares each decoded record with the block.
module scaled_varint_stream_decoder_unit_checker import svdec_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	input  logic                      byte_stall,
	input  logic [BYTE_W-1:0]         in_byte,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [LEN_W-1:0]          record_length,
	output int                        fail_count,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [LEN_W-1:0]   len;
	} decoded_rec_t;

	decoded_rec_t       expected_records[$];
	logic [BYTE_W-1:0]  open_header   = '0;
	logic [2:0]         payload_left  = '0;
	logic [2:0]         payload_index = '0;
	logic [MAG_W-1:0]   magnitude     = '0;
	int                 mismatches    = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Magnitude times the header's scale, then the header's sign, all modulo 2^64.
	function automatic logic [VALUE_W-1:0] scaled_signed(input logic [BYTE_W-1:0] hdr,
			input logic [MAG_W-1:0] mag);
		logic [VALUE_W-1:0] factor;
		logic [VALUE_W-1:0] product;
		case (scale_t'(hdr[1:0]))
			SCALE_1:    factor = 64'd1;
			SCALE_10:   factor = 64'd10;
			SCALE_100:  factor = 64'd100;
			default:    factor = 64'd1000;
		endcase
		product = VALUE_W'(mag) * factor;
		if ((hdr & SIGN_MASK) != '0)
			product = '0 - product;
		return product;
	endfunction

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		decoded_rec_t rec;
		if (payload_left == '0) begin
			if ((b & SMALL_MASK) != '0) begin
				// A small value in the header wins over any payload count.
				rec.value = scaled_signed(b, MAG_W'(b[3:2]));
				rec.len   = LEN_W'(1);
				expected_records.push_back(rec);
			end else if ((b & COUNT_MASK) == '0) begin
				rec.value = scaled_signed(b, '0);
				rec.len   = LEN_W'(1);
				expected_records.push_back(rec);
			end else begin
				open_header   = b;
				payload_left  = b[6:4];
				payload_index = '0;
				magnitude     = '0;
			end
		end else begin
			magnitude     = magnitude | (MAG_W'(b) << (payload_index * 8));
			payload_index = payload_index + 3'd1;
			payload_left  = payload_left - 3'd1;
			if (payload_left == '0) begin
				rec.value = scaled_signed(open_header, magnitude);
				rec.len   = LEN_W'(open_header[6:4]) + LEN_W'(1);
				expected_records.push_back(rec);
				magnitude     = '0;
				payload_index = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_rec_t want;
		if (!arst_n) begin
			open_header   = '0;
			payload_left  = '0;
			payload_index = '0;
			magnitude     = '0;
			expected_records.delete();
			outstanding <= 0;
		end else begin
			// A record's result always lags its last byte, so the check may come first.
			if (result_valid && !result_stall) begin
				if (expected_records.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d length %0d",
						value, record_length));
				end else begin
					want = expected_records.pop_front();
					if (value !== want.value)
						report_mismatch($sformatf("value %0d, expected %0d",
							value, $signed(want.value)));
					if (record_length !== want.len)
						report_mismatch($sformatf("record_length %0d, expected %0d",
							record_length, want.len));
				end
			end
			if (byte_valid && !byte_stall)
				decode_byte(in_byte);
			outstanding <= expected_records.size();
		end
	end

endmodule

### test/scaled_varint_stream_decoder_unit_tb.sv
// Top of the scaled varint stream decoder testbench: clock, reset, byte stream and verdict.
module scaled_varint_stream_decoder_unit_tb;
	import svdec_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      byte_valid;
	logic                      byte_stall;
	logic [BYTE_W-1:0]         in_byte;
	logic                      result_valid;
	logic                      result_stall;
	logic signed [VALUE_W-1:0] value;
	logic [LEN_W-1:0]          record_length;

	int   fail_count;
	int   outstanding;
	int   bytes_sent   = 0;
	int   cycle_count  = 0;
	logic no_idle      = 1'b0;
	logic hold_request = 1'b0;

	// Zero bodies, small values, small value over a count, full payloads and the wrap.
	logic [BYTE_W-1:0] directed_bytes[] = '{
		8'h00, 8'h80, 8'h83, 8'h04, 8'h8f, 8'h7e, 8'hb9,
		8'h10, 8'hff,
		8'h22, 8'h01, 8'h80,
		8'hf3, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	scaled_varint_stream_decoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.in_byte       (in_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.value         (value),
		.record_length (record_length)
	);

	scaled_varint_stream_decoder_unit_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.in_byte       (in_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.value         (value),
		.record_length (record_length),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, none during the quiet stretch, and one long hold-off.
	initial begin
		bit hold_seen;
		hold_seen    = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_seen) begin
				hold_seen = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_stall <= !no_idle && ($urandom_range(99) < 29);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!no_idle && $urandom_range(99) < 29) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte    <= b;
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
	endtask

	// Mostly well-formed records with random content, with some stray bytes mixed in.
	task automatic send_random_record();
		logic [BYTE_W-1:0] hdr;
		int                kind;
		int                fill;
		kind = $urandom_range(99);
		hdr  = BYTE_W'($urandom);
		fill = $urandom_range(9);
		if (kind < 15) begin
			send_byte(BYTE_W'($urandom));
		end else if (kind < 40) begin
			if (hdr[3:2] == 2'b00)
				hdr[3:2] = 2'($urandom_range(1, 3));
			send_byte(hdr);
		end else if (kind < 47) begin
			hdr[6:2] = '0;
			send_byte(hdr);
		end else begin
			hdr[3:2] = 2'b00;
			hdr[6:4] = 3'($urandom_range(1, 7));
			send_byte(hdr);
			repeat (hdr[6:4])
				send_byte(fill == 0 ? 8'hff : fill == 1 ? 8'h00 : BYTE_W'($urandom));
		end
	endtask

	initial begin
		int  random_end;
		bit  quiet_done;
		bit  hold_done;
		bit  drain_done;
		logic [BYTE_W-1:0] hdr;
		quiet_done = 0;
		hold_done  = 0;
		drain_done = 0;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		in_byte    = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		random_end = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < random_end) begin
			if (!quiet_done && bytes_sent >= random_end - 850) begin
				no_idle    <= 1'b1;
				quiet_done = 1;
			end else if (quiet_done && no_idle && bytes_sent >= random_end - 700) begin
				no_idle <= 1'b0;
			end
			if (!hold_done && bytes_sent >= random_end - 550) begin
				// Keep offering one-byte records so that the pipeline fills behind the hold.
				hold_done = 1;
				hold_request <= 1'b1;
				repeat (40) begin
					hdr = BYTE_W'($urandom);
					if (hdr[3:2] == 2'b00)
						hdr[3:2] = 2'b11;
					send_byte(hdr);
				end
			end
			if (!drain_done && bytes_sent >= random_end - 250) begin
				drain_done = 1;
				byte_valid <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
			end
			send_random_record();
		end

		byte_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
